### src/ffba_pkg.sv
// Shared types and constants of the first-fit block allocator.
`timescale 1ns / 1ps
package ffba_pkg;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_OOM     = 3'd1;
  localparam logic [2:0] ST_NOENTRY = 3'd2;
  localparam logic [2:0] ST_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_DOUBLE  = 3'd4;

  localparam logic [1:0] CFG_HEADER = 2'd0;
  localparam logic [1:0] CFG_SPLIT  = 2'd1;
  localparam logic [1:0] CFG_LIMIT  = 2'd2;

  localparam int unsigned WORD_W = 16 + 17 + 1 + 11 + 11;

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_WALK, S_SPLIT_RD, S_SPLIT_WR, S_SPLIT_NX, S_GROW, S_GROW_TAIL,
    S_FREE_MARK, S_PREV_RD, S_PREV_CHK, S_NEXT_RD, S_NEXT_CHK, S_ABS_RD, S_ABS_WR,
    S_ABS_FIX, S_DIV, S_OUT
  } state_e;

  typedef struct packed {
    logic [15:0] start;
    logic [16:0] size;
    logic        free;
    logic [10:0] next;
    logic [10:0] prev;
  } entry_t;

endpackage

### src/ffba_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module ffba_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule

### src/ffba_div.sv
// Restoring divider: 32 by 32 bits, one quotient bit per cycle.
`timescale 1ns / 1ps
module ffba_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] quo_o
);
  logic [31:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [32:0] trial;

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; den_d = den_q; cnt_d = cnt_q; busy_d = busy_q;
    trial = {rem_q, quo_q[31]} - {1'b0, den_q};
    if (start_i) begin
      rem_d = '0; quo_d = num_i; den_d = den_i; cnt_d = 6'd32; busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) rem_d = trial[31:0];
      else rem_d = {rem_q[30:0], quo_q[31]};
      quo_d = {quo_q[30:0], !trial[32]};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d;
  end

  assign done_o = busy_q && cnt_q == 6'd1;
  assign quo_o  = quo_d;
endmodule

### src/first_fit_block_allocator_top.sv
// Top level of the first-fit block allocator: sequencer, block table and counters.
`timescale 1ns / 1ps
// First-fit heap allocator. Blocks live in one table RAM (start, size, free
// mark, links) with registered read; a separate flop vector marks which
// table slots are in use. One request is handled at a time: an allocate
// walks the list, reading and then checking each block, and then takes or
// splits the found block or grows the heap; a free walks the same way and
// then merges the block with its free neighbours. Every result then waits
// for the divider computing the average, unless no allocate was counted.
// The walk visits at most MAX_BLOCKS blocks. Entry 0 is written into the
// RAM right after reset, while the input stalls; no clearing pass is
// needed. Configuration must be written while idle.
module first_fit_block_allocator_top
  import ffba_pkg::*;
#(
  parameter int MAX_BLOCKS = 64,
  parameter int HEAP_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [15:0] size_i,
  input  logic [15:0] address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [15:0] payload_address_o,
  output logic [31:0] alloc_calls_o,
  output logic [31:0] grow_calls_o,
  output logic [31:0] total_bytes_o,
  output logic [15:0] average_bytes_o
);
  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam logic [10:0] NOL = 11'(MAX_BLOCKS);
  localparam logic [17:0] CAP = (HEAP_BYTES < 131072) ? 18'(HEAP_BYTES) : 18'd131072;

  logic [6:0]  hdr_q;
  logic [12:0] msplit_q;
  logic [16:0] lim_q;

  state_e st_q, st_d;
  logic        init_q;
  logic [MAX_BLOCKS-1:0] used_q, used_d;
  logic [IW-1:0] cur_q, cur_d, aux_q, aux_d, tail_q, tail_d;
  logic [IW-1:0] addr;
  logic        we;
  entry_t      wdata, rd, ent_q, ent_d, nb_q, nb_d;
  logic [10:0] steps_q, steps_d;
  logic        rtype_q;
  logic [15:0] size_q, addrin_q;
  logic [16:0] brk_q, brk_d;
  logic [31:0] ac_q, ac_d, gc_q, gc_d, tot_q, tot_d;
  logic [2:0]  stat_q, stat_d;
  logic [15:0] pay_q, pay_d, avg_q, avg_d;
  logic        div_start, div_done;
  logic [31:0] div_quo;
  logic        spare_ok;
  logic [IW-1:0] spare;
  logic [17:0] lim_cap, grow_end;
  logic [17:0] split_need;

  always_comb begin
    spare_ok = 1'b0; spare = '0;
    for (int i = MAX_BLOCKS - 1; i >= 0; i--)
      if (!used_q[i]) begin spare_ok = 1'b1; spare = IW'(i); end
  end

  assign lim_cap    = ({1'b0, lim_q} < CAP) ? {1'b0, lim_q} : CAP;
  assign grow_end   = {1'b0, brk_q} + 18'(hdr_q) + 18'(size_q);
  assign split_need = 18'(size_q) + 18'(hdr_q) + 18'(msplit_q);

  ffba_ram #(.Width(WORD_W), .Depth(MAX_BLOCKS)) u_tbl (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rd)
  );

  ffba_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(tot_q), .den_i(ac_q),
    .done_o(div_done), .quo_o(div_quo)
  );

  // Sequencer: walks the block list, splits, grows and merges blocks, and starts the divider.
  always_comb begin
    st_d = st_q; used_d = used_q; cur_d = cur_q; aux_d = aux_q; tail_d = tail_q;
    ent_d = ent_q; nb_d = nb_q; steps_d = steps_q; brk_d = brk_q;
    ac_d = ac_q; gc_d = gc_q; tot_d = tot_q; stat_d = stat_q; pay_d = pay_q;
    avg_d = avg_q;
    we = 1'b0; addr = cur_q; wdata = ent_q; div_start = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        if (init_q) begin
          we = 1'b1; addr = '0;
          wdata = '{start: 16'd0, size: 17'd0, free: 1'b1, next: NOL, prev: NOL};
        end else if (in_valid_i) begin
          cur_d = '0; steps_d = '0; stat_d = ST_OK; pay_d = '0;
          if (!req_type_i) begin
            ac_d = (ac_q == '1) ? ac_q : ac_q + 32'd1;
            st_d = S_RD;
          end else if (address_i == 16'd0) st_d = S_DIV;
          else st_d = S_RD;
        end
      end
      S_RD: begin
        addr = cur_q; st_d = S_WALK;
      end
      S_WALK: begin
        ent_d = rd;
        st_d = S_RD;
        steps_d = steps_q + 11'd1;
        if (!rtype_q) begin
          if (rd.free && rd.size >= {1'b0, size_q}) begin
            pay_d = rd.start + 16'(hdr_q);
            tot_d = ({1'b0, tot_q} + 33'(size_q) > 33'hFFFFFFFF) ? '1 : tot_q + 32'(size_q);
            if ({1'b0, rd.size} >= split_need && spare_ok) begin
              aux_d = spare; st_d = S_SPLIT_WR;
            end else begin
              we = 1'b1; wdata = rd; wdata.free = 1'b0; st_d = S_DIV;
            end
          end else if (rd.next == NOL || steps_q == 11'(MAX_BLOCKS - 1)) st_d = S_GROW;
          else cur_d = rd.next[IW-1:0];
        end else begin
          if (rd.start + 16'(hdr_q) == addrin_q) begin
            if (rd.free) begin stat_d = ST_DOUBLE; st_d = S_DIV; end
            else st_d = S_FREE_MARK;
          end else if (rd.next == NOL || steps_q == 11'(MAX_BLOCKS - 1)) begin
            stat_d = ST_UNKNOWN; st_d = S_DIV;
          end else cur_d = rd.next[IW-1:0];
        end
      end
      S_SPLIT_WR: begin
        // Write the new free remainder, then shrink and relink the found block.
        we = 1'b1; addr = aux_q;
        wdata = '{start: ent_q.start + 16'(hdr_q) + size_q,
                  size: ent_q.size - 17'(size_q) - 17'(hdr_q),
                  free: 1'b1, next: ent_q.next, prev: 11'(cur_q)};
        used_d[aux_q] = 1'b1;
        st_d = S_SPLIT_RD;
      end
      S_SPLIT_RD: begin
        we = 1'b1; addr = cur_q;
        wdata = ent_q; wdata.free = 1'b0; wdata.size = 17'(size_q); wdata.next = 11'(aux_q);
        steps_d = '0;
        if (ent_q.next == NOL) begin tail_d = aux_q; st_d = S_DIV; end
        else st_d = S_SPLIT_NX;
      end
      S_SPLIT_NX: begin
        addr = ent_q.next[IW-1:0];
        if (steps_q[0]) begin
          we = 1'b1; wdata = rd; wdata.prev = 11'(aux_q); st_d = S_DIV;
        end
        steps_d[0] = 1'b1;
      end
      S_GROW: begin
        gc_d = (gc_q == '1) ? gc_q : gc_q + 32'd1;
        if (brk_q[16] || grow_end > lim_cap) begin stat_d = ST_OOM; st_d = S_DIV; end
        else if (!spare_ok) begin stat_d = ST_NOENTRY; st_d = S_DIV; end
        else begin
          we = 1'b1; addr = spare;
          wdata = '{start: brk_q[15:0], size: 17'(size_q), free: 1'b0, next: NOL,
                    prev: 11'(tail_q)};
          used_d[spare] = 1'b1; aux_d = spare; cur_d = tail_q;
          brk_d = grow_end[16:0];
          tot_d = ({1'b0, tot_q} + 33'(size_q) > 33'hFFFFFFFF) ? '1 : tot_q + 32'(size_q);
          pay_d = brk_q[15:0] + 16'(hdr_q);
          steps_d = '0;
          st_d = S_GROW_TAIL;
        end
      end
      S_GROW_TAIL: begin
        addr = cur_q; steps_d[0] = 1'b1;
        if (steps_q[0]) begin
          we = 1'b1; wdata = rd; wdata.next = 11'(aux_q); tail_d = aux_q; st_d = S_DIV;
        end
      end
      S_FREE_MARK: begin
        we = 1'b1; addr = cur_q; wdata = ent_q; wdata.free = 1'b1;
        ent_d.free = 1'b1;
        st_d = (ent_q.prev == NOL) ? S_NEXT_RD : S_PREV_RD;
      end
      S_PREV_RD: begin
        addr = ent_q.prev[IW-1:0]; st_d = S_PREV_CHK;
      end
      S_PREV_CHK: begin
        // Previous block free: it absorbs the current one.
        if (rd.free) begin
          aux_d = cur_q; cur_d = ent_q.prev[IW-1:0];
          nb_d = ent_q; ent_d = rd; steps_d = '0;
          st_d = S_ABS_WR;
        end else st_d = S_NEXT_RD;
      end
      S_NEXT_RD: begin
        if (ent_q.next == NOL) st_d = S_DIV;
        else begin addr = ent_q.next[IW-1:0]; st_d = S_NEXT_CHK; end
      end
      S_NEXT_CHK: begin
        if (rd.free) begin
          aux_d = ent_q.next[IW-1:0]; nb_d = rd; steps_d = 11'd1; st_d = S_ABS_WR;
        end else st_d = S_DIV;
      end
      S_ABS_WR: begin
        // ent_q (at cur_q) absorbs nb_q (at aux_q).
        we = 1'b1; addr = cur_q;
        wdata = ent_q;
        wdata.size = ent_q.size + nb_q.size + 17'(hdr_q);
        wdata.next = nb_q.next;
        ent_d = wdata;
        used_d[aux_q] = 1'b0;
        if (nb_q.next == NOL) begin
          tail_d = cur_q; st_d = steps_q[0] ? S_DIV : S_NEXT_RD;
        end else st_d = S_ABS_RD;
      end
      S_ABS_RD: begin
        addr = nb_q.next[IW-1:0]; st_d = S_ABS_FIX;
      end
      S_ABS_FIX: begin
        we = 1'b1; addr = nb_q.next[IW-1:0]; wdata = rd; wdata.prev = 11'(cur_q);
        st_d = steps_q[0] ? S_DIV : S_NEXT_RD;
      end
      S_DIV: begin
        if (ac_q == '0) begin avg_d = '0; st_d = S_OUT; end
        else begin div_start = 1'b1; st_d = S_OUT; steps_d = 11'd0; end
      end
      S_OUT: begin
        if (div_done) avg_d = (div_quo > 32'hFFFF) ? 16'hFFFF : div_quo[15:0];
      end
      default: st_d = S_IDLE;
    endcase
  end

  // Output beat: wait for the divider, hold until taken.
  logic busy_div_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; init_q <= 1'b1; used_q <= MAX_BLOCKS'(1);
      tail_q <= '0; brk_q <= 17'd48; ac_q <= '0; gc_q <= '0; tot_q <= '0;
      hdr_q <= 7'd48; msplit_q <= 13'd64; lim_q <= 17'd65536;
      out_valid_o <= 1'b0; busy_div_q <= 1'b0;
    end else begin
      init_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_HEADER: hdr_q <= cfg_data_i[6:0];
          CFG_SPLIT:  msplit_q <= cfg_data_i[12:0];
          CFG_LIMIT:  lim_q <= cfg_data_i;
          default: ;
        endcase
      end
      used_q <= used_d; tail_q <= tail_d; brk_q <= brk_d;
      ac_q <= ac_d; gc_q <= gc_d; tot_q <= tot_d;
      if (st_q == S_DIV) busy_div_q <= (ac_q != '0);
      else if (div_done) busy_div_q <= 1'b0;
      if (st_q == S_OUT && !out_valid_o && !busy_div_q && !(st_q == S_OUT && div_done)) begin
        out_valid_o <= 1'b1;
      end
      if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      if (st_q == S_OUT) begin
        if (out_valid_o && !out_stall_i) st_q <= S_IDLE;
        else st_q <= S_OUT;
      end else st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d; aux_q <= aux_d; ent_q <= ent_d; nb_q <= nb_d; steps_q <= steps_d;
    stat_q <= stat_d; pay_q <= pay_d; avg_q <= avg_d;
    if (st_q == S_IDLE && in_valid_i && !init_q) begin
      rtype_q <= req_type_i; size_q <= size_i; addrin_q <= address_i;
    end
  end

  assign in_stall_o        = !(st_q == S_IDLE) || init_q;
  assign status_o          = stat_q;
  assign payload_address_o = pay_q;
  assign alloc_calls_o     = ac_q;
  assign grow_calls_o      = gc_q;
  assign total_bytes_o     = tot_q;
  assign average_bytes_o   = avg_q;
endmodule
